### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file tlbpt_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### design/tlbpt_pkg.sv
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Sizes, shared types and helpers of the TLB / page-table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

   localparam int PAGE_COUNT  = 256;
   localparam int FRAME_COUNT = 256;
   localparam int PAGE_BYTES  = 256;
   localparam int TLB_ENTRIES = 16;

   localparam int ADDR_W    = 16;
   localparam int OFFSET_W  = $clog2(PAGE_BYTES);
   localparam int PAGE_W    = ADDR_W - OFFSET_W;
   localparam int PIDX_W    = $clog2(PAGE_COUNT);
   localparam int FRAME_W   = $clog2(FRAME_COUNT);
   localparam int FCNT_W    = $clog2(FRAME_COUNT + 1);
   localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
   localparam int PNUM_W    = 8;
   localparam int FNUM_W    = 8;
   localparam int COUNT_W   = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // classified request handed from front to back
   typedef struct packed {
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] offset;
      logic                hit;
      logic [FRAME_W-1:0]  frame;
   } tlbpt_item_type;

   // TLB fill issued by the back end
   typedef struct packed {
      logic               en;
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
   } tlbpt_fill_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

   function automatic logic [PIDX_W-1:0] page_index(input logic [PAGE_W-1:0] page);
      logic [31:0] wide;
      wide = 32'(page) % PAGE_COUNT;
      return wide[PIDX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] phys_addr(input logic [FRAME_W-1:0]  frame,
                                                   input logic [OFFSET_W-1:0] offset);
      logic [31:0] wide;
      wide = (32'(frame) << OFFSET_W) | 32'(offset);
      return wide[ADDR_W-1:0];
   endfunction

endpackage

### design/tlbpt_front.sv
// ----------------------------------------------------------------------------
// tlbpt_front
// Takes a request, splits the address and classifies it against the TLB.
// ----------------------------------------------------------------------------
module tlbpt_front import tlbpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ADDR_W-1:0]    req_logical_address,
   input  tlbpt_fill_type       fill,
   input  logic                 q_full,
   output logic                 push,
   output tlbpt_item_type       item,
   output logic                 front_busy
);

   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               valid_ff, valid_in;
   logic               tlb_valid_ff [TLB_ENTRIES];
   logic [PAGE_W-1:0]  tlb_page_ff  [TLB_ENTRIES];
   logic [FRAME_W-1:0] tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_IDX_W-1:0] fill_ptr_ff, fill_ptr_in;

   logic [PAGE_W-1:0]  page;
   logic               hit;
   logic [FRAME_W-1:0] hit_frame;

   assign page = addr_ff[ADDR_W-1:OFFSET_W];

   // highest matching index wins
   always_comb begin
      hit       = 1'b0;
      hit_frame = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
         if (tlb_valid_ff[i] && (tlb_page_ff[i] == page)) begin
            hit       = 1'b1;
            hit_frame = tlb_frame_ff[i];
         end
      end
   end

   assign push        = valid_ff && !q_full;
   assign item.page   = page;
   assign item.offset = addr_ff[OFFSET_W-1:0];
   assign item.hit    = hit;
   assign item.frame  = hit_frame;
   assign front_busy  = valid_ff;

   always_comb begin
      addr_in     = accept ? req_logical_address : addr_ff;
      valid_in    = accept ? 1'b1 : (push ? 1'b0 : valid_ff);
      fill_ptr_in = fill_ptr_ff;
      if (fill.en) begin
         fill_ptr_in = (fill_ptr_ff == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                       '0 : fill_ptr_ff + TLB_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (fill.en) begin
         tlb_page_ff[fill_ptr_ff]  <= fill.page;
         tlb_frame_ff[fill_ptr_ff] <= fill.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         fill_ptr_ff <= '0;
         for (int i = 0; i < TLB_ENTRIES; i++) begin
            tlb_valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff    <= valid_in;
         fill_ptr_ff <= fill_ptr_in;
         if (fill.en) begin
            tlb_valid_ff[fill_ptr_ff] <= 1'b1;
         end
      end
   end

endmodule

### design/tlbpt_queue.sv
// ----------------------------------------------------------------------------
// tlbpt_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module tlbpt_queue import tlbpt_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tlbpt_item_type push_item,
   input  logic           pop,
   output tlbpt_item_type head_item,
   output logic           empty,
   output logic           full
);

   tlbpt_item_type     store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/tlbpt_back.sv
// ----------------------------------------------------------------------------
// tlbpt_back
// Resolves TLB misses through the page table, allocates frames on fault,
// keeps the statistics counters and drives the response.
// ----------------------------------------------------------------------------
module tlbpt_back import tlbpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  tlbpt_item_type       q_item,
   output logic                 pop,
   output tlbpt_fill_type       fill,
   output logic                 back_busy,
   output logic                 rsp_valid,
   output logic [ADDR_W-1:0]    rsp_physical_address,
   output logic [PNUM_W-1:0]    rsp_page_number,
   output logic [FNUM_W-1:0]    rsp_frame_number,
   output logic                 rsp_tlb_hit,
   output logic                 rsp_page_fault,
   output logic                 rsp_frames_exhausted,
   output logic [COUNT_W-1:0]   rsp_lookup_count,
   output logic [COUNT_W-1:0]   rsp_tlb_hit_count,
   output logic [COUNT_W-1:0]   rsp_fault_count
);

   typedef enum logic {
      S_IDLE,
      S_RESOLVE
   } state_type;

   state_type            state_ff, state_in;
   tlbpt_item_type       item_ff, item_in;
   logic [FCNT_W-1:0]    next_free_ff, next_free_in;
   logic [COUNT_W-1:0]   lookups_ff, lookups_in;
   logic [COUNT_W-1:0]   hits_ff, hits_in;
   logic [COUNT_W-1:0]   faults_ff, faults_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_phys_ff, rsp_phys_in;
   logic [PNUM_W-1:0]    rsp_page_ff, rsp_page_in;
   logic [FNUM_W-1:0]    rsp_frame_ff, rsp_frame_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_fault_ff, rsp_fault_in;
   logic                 rsp_exh_ff, rsp_exh_in;

   // page table: mapped bits in flops, frame numbers in RAM
   logic                 mapped_ff [PAGE_COUNT];
   logic [FRAME_W-1:0]   pf_mem    [PAGE_COUNT];
   logic [FRAME_W-1:0]   pf_rdata_ff;

   logic [PIDX_W-1:0]    pidx;
   logic                 resolving;
   logic                 fault, exhausted, do_map;
   logic [FRAME_W-1:0]   frame;

   assign pop       = (state_ff == S_IDLE) && !q_empty;
   assign resolving = (state_ff == S_RESOLVE);
   assign pidx      = page_index(item_ff.page);
   assign back_busy = resolving;

   always_comb begin
      fault     = 1'b0;
      exhausted = 1'b0;
      do_map    = 1'b0;
      frame     = item_ff.frame;
      if (!item_ff.hit) begin
         if (mapped_ff[pidx]) begin
            frame = pf_rdata_ff;
         end else begin
            fault = 1'b1;
            if (next_free_ff == FCNT_W'(FRAME_COUNT)) begin
               exhausted = 1'b1;
               frame     = '0;
            end else begin
               do_map = 1'b1;
               frame  = FRAME_W'(next_free_ff);
            end
         end
      end
   end

   assign fill.en    = resolving && !item_ff.hit && !exhausted;
   assign fill.page  = item_ff.page;
   assign fill.frame = frame;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      next_free_in = next_free_ff;
      lookups_in   = lookups_ff;
      hits_in      = hits_ff;
      faults_in    = faults_ff;
      rsp_valid_in = 1'b0;
      rsp_phys_in  = rsp_phys_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_exh_in   = rsp_exh_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               item_in  = q_item;
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            lookups_in = sat_inc(lookups_ff);
            if (item_ff.hit) begin
               hits_in = sat_inc(hits_ff);
            end
            if (fault) begin
               faults_in = sat_inc(faults_ff);
            end
            if (do_map) begin
               next_free_in = next_free_ff + FCNT_W'(1);
            end
            rsp_valid_in = 1'b1;
            rsp_phys_in  = phys_addr(frame, item_ff.offset);
            rsp_page_in  = PNUM_W'(item_ff.page);
            rsp_frame_in = FNUM_W'(frame);
            rsp_hit_in   = item_ff.hit;
            rsp_fault_in = fault;
            rsp_exh_in   = exhausted;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_free_ff <= '0;
         lookups_ff   <= '0;
         hits_ff      <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_free_ff <= next_free_in;
         lookups_ff   <= lookups_in;
         hits_ff      <= hits_in;
         faults_ff    <= faults_in;
         rsp_valid_ff <= rsp_valid_in;
         item_ff      <= item_in;
         rsp_phys_ff  <= rsp_phys_in;
         rsp_page_ff  <= rsp_page_in;
         rsp_frame_ff <= rsp_frame_in;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_fault_ff <= rsp_fault_in;
         rsp_exh_ff   <= rsp_exh_in;
      end
   end

   // page-frame RAM: read on pop, written on a new mapping
   always_ff @(posedge clock) begin
      if (pop) begin
         pf_rdata_ff <= pf_mem[page_index(q_item.page)];
      end
      if (resolving && do_map) begin
         pf_mem[pidx] <= frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAGE_COUNT; i++) begin
            mapped_ff[i] <= 1'b0;
         end
      end else if (resolving && do_map) begin
         mapped_ff[pidx] <= 1'b1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_page_number      = rsp_page_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_tlb_hit          = rsp_hit_ff;
   assign rsp_page_fault       = rsp_fault_ff;
   assign rsp_frames_exhausted = rsp_exh_ff;
   assign rsp_lookup_count     = lookups_ff;
   assign rsp_tlb_hit_count    = hits_ff;
   assign rsp_fault_count      = faults_ff;

endmodule

### design/tlb_page_table_translator_core.sv
// ----------------------------------------------------------------------------
// tlb_page_table_translator_core
// Virtual-to-physical translator: TLB, page table and demand frame allocation.
// ----------------------------------------------------------------------------
// Request channel: raise start with req_logical_address; the request is taken
// at a rising edge where start is high and busy is low. Bits above the offset
// are the page, the low bits the offset.
// Response channel: rsp_valid is high for exactly one cycle with the physical
// address, page, frame, hit / fault / exhausted flags and the three
// saturating counters. The receiver cannot stall; it must sample that cycle.
// A request passes the front register, the queue, the page-table RAM read
// and the resolve step before rsp_valid. busy stays high while a request
// is anywhere in flight, so no new request is taken until this one is done,
// since the TLB search of the next request needs the fill written by it.
// Reset (synchronous) empties the TLB, page table, frame allocator, queue
// and counters; no clearing pass is needed, the RAM is guarded by valid bits.
// Frames are handed out in ascending order and never freed, so the lowest
// free frame is simply the allocation count.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_core import tlbpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [ADDR_W-1:0]    req_logical_address,
   output logic                 rsp_valid,
   output logic [ADDR_W-1:0]    rsp_physical_address,
   output logic [PNUM_W-1:0]    rsp_page_number,
   output logic [FNUM_W-1:0]    rsp_frame_number,
   output logic                 rsp_tlb_hit,
   output logic                 rsp_page_fault,
   output logic                 rsp_frames_exhausted,
   output logic [COUNT_W-1:0]   rsp_lookup_count,
   output logic [COUNT_W-1:0]   rsp_tlb_hit_count,
   output logic [COUNT_W-1:0]   rsp_fault_count
);

   logic           accept;
   logic           front_busy, back_busy;
   logic           push, pop, q_empty, q_full;
   tlbpt_item_type push_item, head_item;
   tlbpt_fill_type fill;

   // one request in flight at a time keeps TLB search and fill in order
   assign busy   = front_busy || !q_empty || back_busy;
   assign accept = start && !busy;

   tlbpt_front u_front (
      .clock               (clock),
      .reset               (reset),
      .accept              (accept),
      .req_logical_address (req_logical_address),
      .fill                (fill),
      .q_full              (q_full),
      .push                (push),
      .item                (push_item),
      .front_busy          (front_busy)
   );

   tlbpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   tlbpt_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (q_empty),
      .q_item               (head_item),
      .pop                  (pop),
      .fill                 (fill),
      .back_busy            (back_busy),
      .rsp_valid            (rsp_valid),
      .rsp_physical_address (rsp_physical_address),
      .rsp_page_number      (rsp_page_number),
      .rsp_frame_number     (rsp_frame_number),
      .rsp_tlb_hit          (rsp_tlb_hit),
      .rsp_page_fault       (rsp_page_fault),
      .rsp_frames_exhausted (rsp_frames_exhausted),
      .rsp_lookup_count     (rsp_lookup_count),
      .rsp_tlb_hit_count    (rsp_tlb_hit_count),
      .rsp_fault_count      (rsp_fault_count)
   );

endmodule

### design/tlbpt_checker.sv
// ----------------------------------------------------------------------------
// tlbpt_checker
// Port-level checks of the translator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlbpt_checker import tlbpt_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [FNUM_W-1:0]    rsp_frame_number,
   input logic                 rsp_tlb_hit,
   input logic                 rsp_page_fault,
   input logic                 rsp_frames_exhausted
);

   // a taken request makes the block busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // response comes out only once the pipeline has drained
   `ASSERT_IMPLY(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NEXT(a_single_rsp, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPLY(a_hit_no_fault, clock, reset, rsp_valid && rsp_tlb_hit, !rsp_page_fault)
   `ASSERT_IMPLY(a_exhaust_fault, clock, reset, rsp_valid && rsp_frames_exhausted, rsp_page_fault && rsp_frame_number == '0)

endmodule

bind tlb_page_table_translator_core tlbpt_checker u_checker (.*);
